FILE: rtl/core/mipmap_box_downsampler_top_defines.svh
// Assertion macros shared by the mipmap downsampler checker
`ifndef MIPMAP_BOX_DOWNSAMPLER_TOP_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is low
`define MBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mipmap downsampler check failed");

// Next-cycle implication, off while reset is low
`define MBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mipmap downsampler check failed");

// Next-cycle implication that also holds through reset
`define MBD_ASSERT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mipmap downsampler check failed");

`endif

FILE: rtl/core/mbd_pkg.sv
// Types, constants and helpers of the mipmap box downsampler
package mbd_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_LEVELS = 13;
    localparam int NUM_CELLS  = MAX_LEVELS - 1;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int XY_W       = 11;
    localparam int CH_W       = 8;
    localparam int PSUM_W     = CH_W + 1;
    localparam int QSUM_W     = CH_W + 2;
    localparam int LVL_W      = 4;
    localparam int CNT_W      = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    typedef logic [3:0][CH_W-1:0]   t_texel;   // [3] red .. [0] alpha
    typedef logic [3:0][PSUM_W-1:0] t_psum;

    typedef struct packed {
        logic [XY_W-1:0] col;
        logic [XY_W-1:0] row;
        t_texel          px;
    } t_result;

    typedef struct packed {
        logic                         valid;
        logic                         alive;
        t_texel                       px;
        logic [CNT_W-1:0]             cnt;
        t_result [NUM_CELLS-1:0]      slots;
    } t_token;

    typedef struct packed {
        logic             active;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w1;
        logic [DIM_W-1:0] h1;
    } t_cell_cfg;

    typedef struct packed {
        logic            we;
        logic [XY_W-1:0] waddr;
        t_psum           wdata;
        logic [XY_W-1:0] raddr;
    } t_line_req;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // Dimension of a level: halve k times, never below one
    function automatic logic [DIM_W-1:0] f_level_dim(logic [DIM_W-1:0] base, int k);
        logic [DIM_W-1:0] d;
        d = base >> k;
        return (d == '0) ? DIM_W'(1) : d;
    endfunction

endpackage

FILE: rtl/core/mbd_if.sv
// Texel input and result output channel interfaces
interface mbd_in_if;
    import mbd_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mbd_out_if;
    import mbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] level;
    logic [XY_W-1:0]  col;
    logic [XY_W-1:0]  row;
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [CH_W-1:0]  alpha_out;
    logic             last_of_run;
    modport source (output valid, level, col, row, red_out, green_out, blue_out,
                    alpha_out, last_of_run, input ready);
    modport sink   (input valid, level, col, row, red_out, green_out, blue_out,
                    alpha_out, last_of_run, output ready);
endinterface

FILE: rtl/core/mipmap_box_downsampler_top.sv
// Top level of the streaming 2x2 box-filter mip chain generator
//
//  channel   | dir | beat contents
//  ----------+-----+------------------------------------------------------
//  i_in      | in  | one base texel, RGBA8, raster order
//  o_out     | out | one mip texel: level, col, row, RGBA8, last_of_run
//  APB       | in  | image_width at 0x0, image_height at 0x4
//
//  Takes one texel per cycle. Each texel runs down a row of twelve level
//  cells, one cell per cycle while the chain is not stalled, and its results
//  are collected at the end of the row. A run with n results gives n beats;
//  the input stalls only while a finished run waits behind a busy serializer.
//  Reset is synchronous, active low; it sets both dimensions to 1.
//  A register write restarts the image at position zero on every level.
module mipmap_box_downsampler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0]    paddr,
    input  logic [mbd_pkg::DATA_W-1:0]    pwdata,
    output logic [mbd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    mbd_in_if.sink                        i_in,
    mbd_out_if.source                     o_out
);
    import mbd_pkg::*;

    // Configuration registers, stored already clamped to 1..MAX_DIM
    logic [DIM_W-1:0] r_width, r_height, wr_dim;
    logic             wr_stb;
    t_reg_idx         wr_idx;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite;
    assign wr_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        if (pwdata == '0) begin
            wr_dim = DIM_W'(1);
        end else if (pwdata > DATA_W'(MAX_DIM)) begin
            wr_dim = DIM_W'(MAX_DIM);
        end else begin
            wr_dim = pwdata[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (wr_stb) begin
            case (wr_idx)
                REG_WIDTH:  r_width  <= wr_dim;
                REG_HEIGHT: r_height <= wr_dim;
                default:    r_width  <= r_width;
            endcase
        end
    end

    assign prdata = (wr_idx == REG_HEIGHT) ? DATA_W'(r_height) : DATA_W'(r_width);

    // Level count: position of the top set bit of the larger dimension
    logic [DIM_W-1:0] max_dim;
    logic [CNT_W-1:0] num_levels;

    always_comb begin
        max_dim    = (r_width > r_height) ? r_width : r_height;
        num_levels = '0;
        for (int i = 1; i < DIM_W; i++) begin
            if ((max_dim >> i) != '0) begin
                num_levels = CNT_W'(i);
            end
        end
        if (num_levels > CNT_W'(NUM_CELLS)) begin
            num_levels = CNT_W'(NUM_CELLS);
        end
    end

    // Cell chain
    logic   en;
    t_token tok0;
    t_token tok [NUM_CELLS+1];

    assign i_in.ready = en;

    always_comb begin
        tok0       = '0;
        tok0.valid = i_in.valid;
        tok0.alive = 1'b1;
        tok0.px    = {i_in.red_in, i_in.green_in, i_in.blue_in, i_in.alpha_in};
    end

    assign tok[0] = tok0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        // Line store of this level holds one entry per column pair of the level it reads
        localparam int DEPTH = ((MAX_DIM >> (k + 1)) > 2) ? (MAX_DIM >> (k + 1)) : 2;
        localparam int AW    = $clog2(DEPTH);

        t_cell_cfg cfg;
        t_line_req req;
        t_psum     rdata;

        always_comb begin
            cfg.active = CNT_W'(k) < num_levels;
            cfg.w      = f_level_dim(r_width, k);
            cfg.h      = f_level_dim(r_height, k);
            cfg.w1     = f_level_dim(r_width, k + 1);
            cfg.h1     = f_level_dim(r_height, k + 1);
        end

        mbd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_clr   (wr_stb),
            .i_cfg   (cfg),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1]),
            .o_req   (req),
            .i_rdata (rdata)
        );

        mbd_ram #(
            .DEPTH (DEPTH),
            .AW    (AW),
            .WIDTH ($bits(t_psum))
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (req.we),
            .i_waddr (req.waddr[AW-1:0]),
            .i_wdata (req.wdata),
            .i_raddr (req.raddr[AW-1:0]),
            .o_rdata (rdata)
        );
    end

    // Serialize finished runs; stall the chain while a run waits
    mbd_drain u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tail  (tok[NUM_CELLS]),
        .o_en    (en),
        .o_out   (o_out)
    );
endmodule

FILE: rtl/core/mbd_ram.sv
// Simple dual-port line store, registered read
module mbd_ram #(
    parameter int DEPTH = 2,
    parameter int AW    = 1,
    parameter int WIDTH = 36
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/mbd_cell.sv
// One mip level: position, pair sum, line store access, output stage
module mbd_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_clr,
    input  mbd_pkg::t_cell_cfg i_cfg,
    input  mbd_pkg::t_token   i_tok,
    output mbd_pkg::t_token   o_tok,
    output mbd_pkg::t_line_req o_req,
    input  mbd_pkg::t_psum    i_rdata
);
    import mbd_pkg::*;

    logic [POS_W-1:0] r_col, r_row, n_col, n_row;
    t_texel           r_pair;
    logic             r_fwd, n_fwd;
    t_psum            r_fwd_data;
    t_token           r_tok, n_tok;

    logic             go, upd, col_end, row_end, in_range, wide, tall;
    logic             pair_hold, line_hold, emit;
    logic [XY_W-1:0]  x, y;
    t_psum            p, ln;
    logic [3:0][QSUM_W-1:0] s;
    t_texel           avg;

    always_comb begin
        go      = i_tok.valid && i_tok.alive && i_cfg.active;
        upd     = i_en && go;
        col_end = (DIM_W'(r_col) + DIM_W'(1)) >= i_cfg.w;
        row_end = (DIM_W'(r_row) + DIM_W'(1)) >= i_cfg.h;
        x       = r_col[POS_W-1:1];
        y       = r_row[POS_W-1:1];
        in_range = (DIM_W'(x) < i_cfg.w1) && (DIM_W'(y) < i_cfg.h1);
        wide    = i_cfg.w != DIM_W'(1);
        tall    = i_cfg.h != DIM_W'(1);
        pair_hold = go && in_range && wide && !r_col[0];
        line_hold = go && in_range && !pair_hold && tall && !r_row[0];
        emit      = go && in_range && !pair_hold && !line_hold;
        ln = r_fwd ? r_fwd_data : i_rdata;
        for (int ch = 0; ch < 4; ch++) begin
            p[ch] = wide ? ({1'b0, i_tok.px[ch]} + {1'b0, r_pair[ch]})
                         : {1'b0, i_tok.px[ch]};
            s[ch] = tall ? ({1'b0, p[ch]} + {1'b0, ln[ch]}) : {1'b0, p[ch]};
            case ({wide, tall})
                2'b11:        avg[ch] = s[ch][CH_W+1:2];
                2'b10, 2'b01: avg[ch] = s[ch][CH_W:1];
                default:      avg[ch] = s[ch][CH_W-1:0];
            endcase
        end
    end

    // Advance the level position; wrap at the end of the level, restart at zero on a clear
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_clr) begin
            n_col = '0;
            n_row = '0;
        end else if (upd) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + POS_W'(1);
            end else begin
                n_col = r_col + POS_W'(1);
            end
        end
    end

    // Prefetch the line entry of the next texel; forward a same-cycle write
    always_comb begin
        o_req.we    = i_en && line_hold;
        o_req.waddr = x;
        o_req.wdata = p;
        o_req.raddr = n_col[POS_W-1:1];
        n_fwd       = o_req.we && (x == o_req.raddr);
    end

    always_comb begin
        n_tok       = i_tok;
        n_tok.alive = emit;
        if (emit) begin
            n_tok.px               = avg;
            n_tok.slots[i_tok.cnt] = '{col: x, row: y, px: avg};
            n_tok.cnt              = i_tok.cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_fwd <= 1'b0;
            r_tok <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_fwd <= n_fwd;
            if (i_en) begin
                r_tok <= n_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= p;
        if (upd && pair_hold) begin
            r_pair <= i_tok.px;
        end
    end

    assign o_tok = r_tok;
endmodule

FILE: rtl/core/mbd_drain.sv
// Result serializer: takes a finished run and hands out one beat per result
module mbd_drain (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbd_pkg::t_token i_tail,
    output logic            o_en,
    mbd_out_if.source       o_out
);
    import mbd_pkg::*;

    logic                    r_busy;
    logic [CNT_W-1:0]        r_left;
    logic [LVL_W-1:0]        r_lvl;
    t_result [NUM_CELLS-1:0] r_slots;
    logic                    offer, fire, free, load;

    always_comb begin
        offer = i_tail.valid && (i_tail.cnt != '0);
        fire  = r_busy && o_out.ready;
        free  = !r_busy || (o_out.ready && r_left == CNT_W'(1));
        o_en  = !offer || free;
        load  = offer && free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (fire && r_left == CNT_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left  <= i_tail.cnt;
            r_lvl   <= LVL_W'(1);
            r_slots <= i_tail.slots;
        end else if (fire) begin
            r_left  <= r_left - CNT_W'(1);
            r_lvl   <= r_lvl + LVL_W'(1);
            r_slots <= r_slots >> $bits(t_result);
        end
    end

    assign o_out.valid       = r_busy;
    assign o_out.level       = r_lvl;
    assign o_out.col         = r_slots[0].col;
    assign o_out.row         = r_slots[0].row;
    assign o_out.red_out     = r_slots[0].px[3];
    assign o_out.green_out   = r_slots[0].px[2];
    assign o_out.blue_out    = r_slots[0].px[1];
    assign o_out.alpha_out   = r_slots[0].px[0];
    assign o_out.last_of_run = r_left == CNT_W'(1);
endmodule

FILE: rtl/core/mbd_checker.sv
// Port-level checks of the mipmap downsampler, bound to the top level
`include "mipmap_box_downsampler_top_defines.svh"

module mbd_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   pready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [mbd_pkg::LVL_W-1:0] out_level
);
    import mbd_pkg::*;

    `MBD_ASSERT_IMP(a_level_range, i_clk, i_rst_n, out_valid, (out_level >= LVL_W'(1)) && (out_level <= LVL_W'(NUM_CELLS)))
    `MBD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `MBD_ASSERT_ANY(a_rst_quiet, i_clk, !i_rst_n, !out_valid)
    `MBD_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind mipmap_box_downsampler_top mbd_checker u_mbd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .pready    (pready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_level (o_out.level)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the streaming mip chain generator
`timescale 1ns / 1ps

module tb_top;
    import mbd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_tb_texel;

    typedef struct {
        logic [LVL_W-1:0] level;
        logic [XY_W-1:0]  col;
        logic [XY_W-1:0]  row;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             last;
    } t_tb_mip;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    mbd_in_if  tex_in ();
    mbd_out_if mip_out ();

    mipmap_box_downsampler_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (tex_in),
        .o_out   (mip_out)
    );

    always #6 i_clk = ~i_clk;

    // Mirror of the block: dimensions, per-level cursors and partial sums
    int unsigned img_w, img_h, lvl_count;
    int unsigned lw [MAX_LEVELS];
    int unsigned lh [MAX_LEVELS];
    int unsigned lbase [MAX_LEVELS];
    int unsigned col_pos [MAX_LEVELS];
    int unsigned row_pos [MAX_LEVELS];
    int unsigned h_pair [MAX_LEVELS][4];
    int unsigned row_store [MAX_DIM][4];

    t_tb_texel texel_queue [$];
    t_tb_mip   mip_expected [$];
    int        err_count = 0;
    int        cycle_count = 0;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // Recompute level geometry and restart every cursor
    function automatic void rebuild_levels();
        int unsigned m;
        m = (img_w > img_h) ? img_w : img_h;
        lvl_count = 0;
        while (m > 1 && lvl_count < MAX_LEVELS - 1) begin
            m = m >> 1;
            lvl_count++;
        end
        lw[0] = img_w;
        lh[0] = img_h;
        lbase[0] = 0;
        for (int k = 1; k < MAX_LEVELS; k++) begin
            lw[k] = (lw[k-1] / 2 == 0) ? 1 : lw[k-1] / 2;
            lh[k] = (lh[k-1] / 2 == 0) ? 1 : lh[k-1] / 2;
            lbase[k] = (k == 1) ? 0 : lbase[k-1] + lw[k-1];
        end
        for (int k = 0; k < MAX_LEVELS; k++) begin
            col_pos[k] = 0;
            row_pos[k] = 0;
        end
    endfunction

    // Push one base texel through the level chain, queue what it produces
    function automatic void predict_mips(t_tb_texel t);
        int unsigned v [4];
        int unsigned p [4];
        int unsigned c, r, w, h, x, y, sh, idx;
        int n;
        t_tb_mip e;
        n = 0;
        v[0] = 32'(t.red); v[1] = 32'(t.green); v[2] = 32'(t.blue); v[3] = 32'(t.alpha);
        for (int k = 0; k < lvl_count; k++) begin
            c = col_pos[k]; r = row_pos[k];
            w = lw[k]; h = lh[k];
            x = c / 2; y = r / 2;
            sh = 0;
            if (c + 1 >= w) begin
                col_pos[k] = 0;
                row_pos[k] = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_pos[k] = c + 1;
            end
            if (x >= lw[k+1] || y >= lh[k+1]) break;
            if (w > 1) begin
                if (c[0] == 1'b0) begin
                    for (int ch = 0; ch < 4; ch++) h_pair[k][ch] = v[ch];
                    break;
                end
                for (int ch = 0; ch < 4; ch++) p[ch] = v[ch] + h_pair[k][ch];
                sh++;
            end else begin
                for (int ch = 0; ch < 4; ch++) p[ch] = v[ch];
            end
            idx = lbase[k+1] + x;
            if (h > 1) begin
                if (idx >= MAX_DIM) break;
                if (r[0] == 1'b0) begin
                    for (int ch = 0; ch < 4; ch++) row_store[idx][ch] = p[ch];
                    break;
                end
                for (int ch = 0; ch < 4; ch++) p[ch] += row_store[idx][ch];
                sh++;
            end
            for (int ch = 0; ch < 4; ch++) v[ch] = (p[ch] >> sh) & 8'hFF;
            e.level = LVL_W'(k + 1);
            e.col = XY_W'(x);
            e.row = XY_W'(y);
            e.red = 8'(v[0]); e.green = 8'(v[1]); e.blue = 8'(v[2]); e.alpha = 8'(v[3]);
            e.last = 1'b0;
            mip_expected.push_back(e);
            n++;
        end
        if (n > 0) mip_expected[mip_expected.size()-1].last = 1'b1;
    endfunction

    // Driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    t_tb_texel cur_texel;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tex_in.valid <= 1'b0;
            tex_in.red_in <= '0;
            tex_in.green_in <= '0;
            tex_in.blue_in <= '0;
            tex_in.alpha_in <= '0;
        end else if (!(tex_in.valid && !tex_in.ready)) begin
            // current beat taken (or none offered): predict it, pick the next
            if (tex_in.valid) predict_mips(cur_texel);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                tex_in.valid <= 1'b0;
            end else if (texel_queue.size() > 0) begin
                cur_texel = texel_queue.pop_front();
                tex_in.valid <= 1'b1;
                tex_in.red_in <= cur_texel.red;
                tex_in.green_in <= cur_texel.green;
                tex_in.blue_in <= cur_texel.blue;
                tex_in.alpha_in <= cur_texel.alpha;
                if (burst_left <= 1) begin
                    burst_left <= int'($urandom_range(1, 30));
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                tex_in.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern is redrawn at random when its age counter wraps; one long hold on request
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;
    int   stall_mode = 0;
    int   mode_age = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mip_out.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 600;
            mip_out.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            mip_out.ready <= 1'b0;
        end else begin
            if (mode_age == 63) begin
                mode_age <= 0;
                stall_mode <= int'($urandom_range(0, 2));
            end else begin
                mode_age <= mode_age + 1;
            end
            case (stall_mode)
                0: begin
                    mip_out.ready <= 1'b1;
                end
                1: begin
                    mip_out.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    mip_out.ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Monitor: compare each taken beat with the oldest expected mip texel
    always @(posedge i_clk) begin
        t_tb_mip e;
        if (i_rst_n && mip_out.valid && mip_out.ready) begin
            if (mip_expected.size() == 0) begin
                $display("%0t: unexpected beat L%0d (%0d,%0d)", $time,
                         mip_out.level, mip_out.col, mip_out.row);
                err_count++;
            end else begin
                e = mip_expected.pop_front();
                if (mip_out.level !== e.level || mip_out.col !== e.col ||
                    mip_out.row !== e.row || mip_out.red_out !== e.red ||
                    mip_out.green_out !== e.green || mip_out.blue_out !== e.blue ||
                    mip_out.alpha_out !== e.alpha || mip_out.last_of_run !== e.last) begin
                    $display("%0t: expected L%0d (%0d,%0d) %h %h %h %h last %b", $time,
                             e.level, e.col, e.row, e.red, e.green, e.blue, e.alpha,
                             e.last);
                    $display("%0t:   actual L%0d (%0d,%0d) %h %h %h %h last %b", $time,
                             mip_out.level, mip_out.col, mip_out.row, mip_out.red_out,
                             mip_out.green_out, mip_out.blue_out, mip_out.alpha_out,
                             mip_out.last_of_run);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL mipmap_box_downsampler_top");
            $finish;
        end
    end

    task automatic apb_write(t_reg_idx idx, int unsigned value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_WIDTH) img_w = clamp_dim(value);
        else img_h = clamp_dim(value);
        rebuild_levels();
    endtask

    // Hold until every queued texel is taken and every result is back
    task automatic wait_idle();
        while (texel_queue.size() > 0 || tex_in.valid || mip_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(int unsigned w, int unsigned h);
        wait_idle();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
    endtask

    task automatic queue_texels(int count, int pat);
        t_tb_texel t;
        for (int i = 0; i < count; i++) begin
            case (pat)
                0: begin
                    t = '{8'h00, 8'h00, 8'h00, 8'h00};
                end
                1: begin
                    t = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
                end
                default: begin
                    t.red = 8'($urandom_range(0, 255));
                    t.green = 8'($urandom_range(0, 255));
                    t.blue = 8'($urandom_range(0, 255));
                    t.alpha = 8'($urandom_range(0, 255));
                end
            endcase
            texel_queue.push_back(t);
        end
    endtask

    initial begin
        int items;
        int extra;
        int unsigned w, h;
        img_w = 1;
        img_h = 1;
        for (int i = 0; i < MAX_LEVELS; i++)
            for (int ch = 0; ch < 4; ch++) h_pair[i][ch] = 0;
        rebuild_levels();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one by one after reset: no levels at all
        queue_texels(1, 0);
        queue_texels(1, 1);
        queue_texels(1, 2);
        // smallest real image, full scale both ways
        set_dims(2, 2);
        queue_texels(4, 1);
        queue_texels(4, 0);
        // odd row and column dropped
        set_dims(3, 3);
        queue_texels(9, 2);
        // out-of-range writes clamp: zero to one, too large to the maximum
        set_dims(0, 8191);
        queue_texels(8, 2);
        set_dims(4096, 1);
        queue_texels(12, 2);
        items = 40;

        // random whole images, a few cut short
        while (items < 200) begin
            if ($urandom_range(0, 5) == 0) begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 6);
            end else begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 10);
            end
            set_dims(w, h);
            if (!hold_done && items > 120) begin
                @(posedge i_clk);
                hold_req <= 1'b1;
            end
            for (int n = int'($urandom_range(1, 2)); n > 0 && items + w * h <= 220; n--) begin
                queue_texels(int'(w * h), 2);
                items += int'(w * h);
            end
            if ($urandom_range(0, 7) == 0) begin
                extra = int'($urandom_range(1, 5));
                queue_texels(extra, 2);
                items += extra;
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("PASS mipmap_box_downsampler_top");
        end else begin
            $display("FAIL mipmap_box_downsampler_top");
        end
        $finish;
    end

endmodule
